### rtl/stimulus_window_current_sum_unit_defines.svh
// Assertion macros shared by the stimulus window current sum unit.
`ifndef STIMULUS_WINDOW_CURRENT_SUM_UNIT_DEFINES_SVH
`define STIMULUS_WINDOW_CURRENT_SUM_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SWCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/swcs_pkg.sv
// Shared types and constants of the stimulus window current sum unit.
package swcs_pkg;

  localparam int unsigned FUNC_W    = 1;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned NEURON_W  = 10;
  localparam int unsigned TICK_IN_W = 32;
  localparam int unsigned CUR_W     = 32;
  localparam int unsigned CFG_W     = 7;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_en;     // store the presented window
    logic start_query;  // latch the query, clear accumulator and index
    logic rd_issue;     // read the entry at the scan index and advance
    logic finish_load;  // load the saturated sum into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;     // no entries in use
    logic scan_last;    // the scan index points at the last entry in use
    logic out_free;     // the output register can take a new result
  } sts_t;

endpackage

### rtl/swcs_ctrl.sv
// Controller state machine of the stimulus window current sum unit.
`include "stimulus_window_current_sum_unit_defines.svh"

module swcs_ctrl
  import swcs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  func_t in_func,
  output logic  in_ready,
  input  sts_t  sts,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FUNC_WRITE) begin
            cmd.write_en = 1'b1;
          end else begin
            cmd.start_query = 1'b1;
            state_nxt = sts.cnt_zero ? ST_FINISH : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `SWCS_ASSERT_NEXT(a_finish_holds, (state_r == ST_FINISH) && !sts.out_free,
    state_r == ST_FINISH, "result dropped while output register was busy")
  `SWCS_ASSERT_NOW(a_no_write_in_scan, cmd.rd_issue,
    !cmd.write_en && !cmd.start_query, "write or new query during a scan")

endmodule

### rtl/swcs_dpath.sv
// Datapath of the stimulus window current sum unit: window store, scan and sum.
`include "stimulus_window_current_sum_unit_defines.svh"

module swcs_dpath
  import swcs_pkg::*;
#(
  parameter int unsigned WINDOWS   = 64,
  parameter int unsigned TICK_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic [SLOT_W-1:0]       in_window_slot,
  input  logic [NEURON_W-1:0]     in_neuron_id,
  input  logic [TICK_IN_W-1:0]    in_start_tick,
  input  logic [TICK_IN_W-1:0]    in_end_tick,
  input  logic signed [CUR_W-1:0] in_amplitude,
  input  logic [TICK_IN_W-1:0]    in_query_tick,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [CUR_W-1:0] out_sum_current
);

  localparam int unsigned AW    = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
  localparam int unsigned CW    = $clog2(WINDOWS + 1);
  localparam int unsigned TW    = (TICK_BITS < TICK_IN_W) ? TICK_BITS : TICK_IN_W;
  localparam int unsigned SUM_W = CUR_W + AW + 1;
  localparam logic signed [SUM_W-1:0] MAX_V = {{(SUM_W-CUR_W+1){1'b0}}, {(CUR_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] MIN_V = {{(SUM_W-CUR_W+1){1'b1}}, {(CUR_W-1){1'b0}}};

  // Window store.
  logic [NEURON_W-1:0]     mem_neuron [WINDOWS];
  logic [TW-1:0]           mem_start  [WINDOWS];
  logic [TW-1:0]           mem_end    [WINDOWS];
  logic signed [CUR_W-1:0] mem_cur    [WINDOWS];
  logic [WINDOWS-1:0]      valid_r;

  logic [CFG_W-1:0]        cfg_r;
  logic [CW-1:0]           cnt_eff;
  logic [AW-1:0]           idx_r;
  logic [NEURON_W-1:0]     q_neuron_r;
  logic [TW-1:0]           q_tick_r;

  logic [NEURON_W-1:0]     rd_neuron_r;
  logic [TW-1:0]           rd_start_r;
  logic [TW-1:0]           rd_end_r;
  logic signed [CUR_W-1:0] rd_cur_r;
  logic                    rd_ok_r;
  logic                    rd_vld_r;

  logic signed [SUM_W-1:0] acc_r;
  logic signed [SUM_W-1:0] acc_nxt;
  logic                    hit;
  logic                    slot_ok;
  logic [AW-1:0]           wr_addr;
  logic                    out_valid_r;
  logic signed [CUR_W-1:0] out_data_r;
  logic signed [CUR_W-1:0] sat_sum;

  assign slot_ok = (32'(in_window_slot) < WINDOWS);
  assign wr_addr = AW'(in_window_slot);
  assign cnt_eff = (32'(cfg_r) > WINDOWS) ? CW'(WINDOWS) : CW'(cfg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.write_en && slot_ok) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_en && slot_ok) begin
      mem_neuron[wr_addr] <= in_neuron_id;
      mem_start[wr_addr]  <= in_start_tick[TW-1:0];
      mem_end[wr_addr]    <= in_end_tick[TW-1:0];
      mem_cur[wr_addr]    <= in_amplitude;
    end
  end

  always_ff @(posedge clk) begin
    rd_neuron_r <= mem_neuron[idx_r];
    rd_start_r  <= mem_start[idx_r];
    rd_end_r    <= mem_end[idx_r];
    rd_cur_r    <= mem_cur[idx_r];
    rd_ok_r     <= valid_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      rd_vld_r <= cmd.rd_issue;
      if (cmd.start_query) begin
        idx_r <= '0;
      end else if (cmd.rd_issue) begin
        idx_r <= idx_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      q_neuron_r <= in_neuron_id;
      q_tick_r   <= in_query_tick[TW-1:0];
    end
  end

  assign hit = rd_ok_r && (rd_neuron_r == q_neuron_r) &&
               (q_tick_r >= rd_start_r) && (q_tick_r < rd_end_r);

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.start_query) begin
      acc_nxt = '0;
    end else if (rd_vld_r && hit) begin
      acc_nxt = acc_r + SUM_W'(rd_cur_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  always_comb begin
    if (acc_r > MAX_V) begin
      sat_sum = MAX_V[CUR_W-1:0];
    end else if (acc_r < MIN_V) begin
      sat_sum = MIN_V[CUR_W-1:0];
    end else begin
      sat_sum = acc_r[CUR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_load) begin
      out_data_r <= sat_sum;
    end
  end

  assign sts.cnt_zero  = (cnt_eff == '0);
  assign sts.scan_last = (CW'(idx_r) == cnt_eff - CW'(1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_sum_current = out_data_r;

  `SWCS_ASSERT_NEXT(a_acc_cleared, cmd.start_query, acc_r == '0,
    "accumulator not cleared at query start")
  `SWCS_ASSERT_NOW(a_result_from_load, $rose(out_valid_r), $past(cmd.finish_load),
    "result appeared without a load command")

endmodule

### rtl/stimulus_window_current_sum_unit.sv
// Top level of the stimulus window current sum unit.
//
// The block keeps a table of stimulus windows (target neuron, start tick,
// exclusive end tick, signed Q16.16 current) and answers current queries.
// Items arrive on the in_ channel with valid and ready. An item with func
// write stores one window by slot and gives no result; a slot beyond the
// table is ignored. An item with func query gives one result on the out_
// channel: the sum of the currents of all valid windows, among the first
// active_windows slots, that target the neuron and contain the tick, clamped
// to the signed 32-bit range.
// A write is stored as it is accepted. A query with N slots in use reads one
// table entry per cycle through a single memory port, adds the last entry
// and loads its result; the next item is accepted in the cycle after the
// load. The cfg_ port writes active_windows with no wait; the user writes it
// only while idle, as the block does not enforce this. The result sits in an
// output register, so a new item is accepted while a result still waits; a
// query that finishes while the receiver stalls holds its sum until the
// register frees. Reset clears the valid bits, the count and all control
// state; window contents are undefined until written.

module stimulus_window_current_sum_unit
  import swcs_pkg::*;
#(
  parameter int unsigned WINDOWS   = 64,
  parameter int unsigned TICK_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [FUNC_W-1:0]       in_func,
  input  logic [SLOT_W-1:0]       in_window_slot,
  input  logic [NEURON_W-1:0]     in_neuron_id,
  input  logic [TICK_IN_W-1:0]    in_start_tick,
  input  logic [TICK_IN_W-1:0]    in_end_tick,
  input  logic signed [CUR_W-1:0] in_amplitude,
  input  logic [TICK_IN_W-1:0]    in_query_tick,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [CUR_W-1:0] out_sum_current
);

  // Commands and status between the controller and the datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller sequences writes, the scan and the result load.
  swcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (func_t'(in_func)),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the window store, the comparator, the accumulator
  // and the output register.
  swcs_dpath #(
    .WINDOWS   (WINDOWS),
    .TICK_BITS (TICK_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_window_slot  (in_window_slot),
    .in_neuron_id    (in_neuron_id),
    .in_start_tick   (in_start_tick),
    .in_end_tick     (in_end_tick),
    .in_amplitude    (in_amplitude),
    .in_query_tick   (in_query_tick),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sum_current (out_sum_current)
  );

endmodule

### bench/stimulus_window_current_sum_unit_tb.sv
// Self-checking testbench for the stimulus window current sum unit.
`timescale 1ns / 100ps

module stimulus_window_current_sum_unit_tb
  import swcs_pkg::*;
();

  // The table size and tick width match the defaults of the block.
  localparam int unsigned WINDOWS = 64;

  // A query scans every slot in use before its result loads, so this many
  // quiet cycles guarantees the block is idle before a register write.
  localparam int unsigned SETTLE_CYCLES = WINDOWS + 8;

  // Generous bound on the whole run: the slowest correct run is roughly
  // two thousand items.
  localparam int unsigned CYCLE_LIMIT = 800000;

  localparam longint CUR_MAX = 64'sd2147483647;
  localparam longint CUR_MIN = -64'sd2147483648;

  // One input item, with every field the channel carries.
  typedef struct {
    func_t                   func;
    logic [SLOT_W-1:0]       slot;
    logic [NEURON_W-1:0]     neuron;
    logic [TICK_IN_W-1:0]    start_tk;
    logic [TICK_IN_W-1:0]    stop_tk;
    logic signed [CUR_W-1:0] amp;
    logic [TICK_IN_W-1:0]    qtick;
  } stim_item_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_W-1:0]        cfg_wdata;
  logic                    in_valid;
  logic                    in_ready;
  logic [FUNC_W-1:0]       in_func;
  logic [SLOT_W-1:0]       in_window_slot;
  logic [NEURON_W-1:0]     in_neuron_id;
  logic [TICK_IN_W-1:0]    in_start_tick;
  logic [TICK_IN_W-1:0]    in_end_tick;
  logic signed [CUR_W-1:0] in_amplitude;
  logic [TICK_IN_W-1:0]    in_query_tick;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [CUR_W-1:0] out_sum_current;

  // Our own copy of the window table and of the active count register.
  bit                      tbl_valid [WINDOWS];
  logic [NEURON_W-1:0]     tbl_neuron [WINDOWS];
  logic [TICK_IN_W-1:0]    tbl_start [WINDOWS];
  logic [TICK_IN_W-1:0]    tbl_stop [WINDOWS];
  logic signed [CUR_W-1:0] tbl_amp [WINDOWS];
  logic [CFG_W-1:0]        model_count;

  // Summed currents still owed by the block, oldest first.
  logic signed [CUR_W-1:0] expected_currents [$];

  int unsigned error_count;
  int unsigned cycle_count;
  bit          burst_mode;

  // Each random phase concentrates on a few neurons and a narrow span of
  // ticks, otherwise almost no query would ever hit a window.
  logic [NEURON_W-1:0]  neuron_pool [4];
  logic [TICK_IN_W-1:0] tick_base;

  stimulus_window_current_sum_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_window_slot  (in_window_slot),
    .in_neuron_id    (in_neuron_id),
    .in_start_tick   (in_start_tick),
    .in_end_tick     (in_end_tick),
    .in_amplitude    (in_amplitude),
    .in_query_tick   (in_query_tick),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sum_current (out_sum_current)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random about thirty percent of the time, except while a
  // burst is running, when it takes every result at once.
  initial out_ready = 1'b0;
  always @(posedge clk) begin
    out_ready <= burst_mode || ($urandom_range(99) >= 30);
  end

  // Watchdog: a run that has not finished by now is stuck.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("stimulus_window_current_sum_unit verification failed");
    $finish;
  end

  // Saturated sum of the currents of the windows that contain the tick and
  // target the neuron, looking only at the slots in use.
  function automatic logic signed [CUR_W-1:0] summed_current(
    input logic [NEURON_W-1:0] neuron, input logic [TICK_IN_W-1:0] tick);
    longint acc;
    int     span;
    acc  = 0;
    span = (int'(model_count) > int'(WINDOWS)) ? int'(WINDOWS) : int'(model_count);
    for (int i = 0; i < span; i++) begin
      // A window with start at or past its end can never satisfy both bounds.
      if (tbl_valid[i] && tbl_neuron[i] == neuron &&
          tick >= tbl_start[i] && tick < tbl_stop[i]) begin
        acc += tbl_amp[i];
      end
    end
    // Only the final sum is clamped, never the running total.
    if (acc > CUR_MAX) begin
      acc = CUR_MAX;
    end else if (acc < CUR_MIN) begin
      acc = CUR_MIN;
    end
    return acc[CUR_W-1:0];
  endfunction

  // Updates the table copy for a write, or records the sum that a query owes.
  function automatic void record_accepted(input stim_item_t it);
    if (it.func == FUNC_WRITE) begin
      // A rewrite simply replaces whatever the slot held before.
      tbl_valid[it.slot]  = 1'b1;
      tbl_neuron[it.slot] = it.neuron;
      tbl_start[it.slot]  = it.start_tk;
      tbl_stop[it.slot]   = it.stop_tk;
      tbl_amp[it.slot]    = it.amp;
    end else begin
      expected_currents.insert(expected_currents.size(),
                               summed_current(it.neuron, it.qtick));
    end
  endfunction

  // Every field random, including those the operation ignores.
  function automatic stim_item_t noise_item();
    stim_item_t it;
    it.func     = func_t'($urandom_range(1));
    it.slot     = SLOT_W'($urandom);
    it.neuron   = NEURON_W'($urandom);
    it.start_tk = $urandom;
    it.stop_tk  = $urandom;
    it.amp      = $urandom;
    it.qtick    = $urandom;
    return it;
  endfunction

  // A well-formed item around the current phase's neurons and ticks, with a
  // share of noise, reversed windows and extreme currents mixed in.
  function automatic stim_item_t phase_item(input int unsigned write_pct);
    stim_item_t  it;
    logic [31:0] swap;
    int unsigned pick;
    it = noise_item();
    if ($urandom_range(99) < 5) begin
      return it;
    end
    it.func = ($urandom_range(99) < write_pct) ? FUNC_WRITE : FUNC_QUERY;
    if ($urandom_range(99) < 88) begin
      it.neuron = neuron_pool[2'($urandom_range(3))];
    end
    if ($urandom_range(99) < 85) begin
      // Ticks may wrap past the top of the range, which reverses the window.
      it.start_tk = tick_base + $urandom_range(200);
      it.stop_tk  = it.start_tk + $urandom_range(300);
      it.qtick    = tick_base + $urandom_range(520);
    end
    if ($urandom_range(99) < 5) begin
      swap        = it.start_tk;
      it.start_tk = it.stop_tk;
      it.stop_tk  = swap;
    end
    pick = $urandom_range(99);
    if (pick < 65) begin
      it.amp = $urandom_range(32'h0004_0000) - 32'h0002_0000;
    end else if (pick >= 85) begin
      // Near the limits, so that a few matches drive the sum into saturation.
      it.amp = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(255)
                                 : 32'h8000_0000 + $urandom_range(255);
    end
    return it;
  endfunction

  // Starts a new phase of random traffic around fresh neurons and ticks.
  task automatic new_phase_pool();
    for (int i = 0; i < 4; i++) begin
      neuron_pool[i] = NEURON_W'($urandom);
    end
    if ($urandom_range(3) == 0) begin
      tick_base = 32'hFFFF_FF00 + $urandom_range(255);
    end else if ($urandom_range(3) == 0) begin
      tick_base = $urandom_range(255);
    end else begin
      tick_base = $urandom;
    end
  endtask

  // Presents one item and holds it until the block accepts it. Gaps with
  // valid low come first, so a valid that stays high is never lowered.
  task automatic send_item(input stim_item_t it);
    if (!burst_mode) begin
      while ($urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_func        <= it.func;
    in_window_slot <= it.slot;
    in_neuron_id   <= it.neuron;
    in_start_tick  <= it.start_tk;
    in_end_tick    <= it.stop_tk;
    in_amplitude   <= it.amp;
    in_query_tick  <= it.qtick;
    do begin
      @(posedge clk);
    end while (!in_ready);
    record_accepted(it);
  endtask

  task automatic send_write(input logic [SLOT_W-1:0] slot, input logic [NEURON_W-1:0] neuron,
                            input logic [TICK_IN_W-1:0] start_tk,
                            input logic [TICK_IN_W-1:0] stop_tk,
                            input logic signed [CUR_W-1:0] amp);
    stim_item_t it;
    it          = noise_item();
    it.func     = FUNC_WRITE;
    it.slot     = slot;
    it.neuron   = neuron;
    it.start_tk = start_tk;
    it.stop_tk  = stop_tk;
    it.amp      = amp;
    send_item(it);
  endtask

  task automatic send_query(input logic [NEURON_W-1:0] neuron,
                            input logic [TICK_IN_W-1:0] tick);
    stim_item_t it;
    it        = noise_item();
    it.func   = FUNC_QUERY;
    it.neuron = neuron;
    it.qtick  = tick;
    send_item(it);
  endtask

  // Stops sending and waits for every owed result. With settle set it also
  // lets a trailing write or scan finish, so the block is truly idle.
  task automatic drain_results(input bit settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_currents.size() != 0) begin
      @(posedge clk);
    end
    if (settle) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  // Writes the active count, only ever from an idle block.
  task automatic set_window_count(input logic [CFG_W-1:0] count);
    drain_results(1'b1);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_count = count;
  endtask

  // Result checker: every accepted result must match the oldest owed sum.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_currents.size() == 0) begin
        error_count++;
        $display("%0t unexpected result: expected none actual sum_current %0d",
                 $time, out_sum_current);
      end else begin
        if (out_sum_current !== expected_currents[0]) begin
          error_count++;
          $display("%0t mismatch sum_current: expected %0d (%h) actual %0d (%h)",
                   $time, expected_currents[0], expected_currents[0],
                   out_sum_current, out_sum_current);
        end
        void'(expected_currents.pop_front());
      end
    end
  end

  // After reset nothing is in use, so every query must come back as zero.
  task automatic test_empty_table();
    send_query(10'd5, 32'd0);
    send_query(10'h3FF, 32'hFFFF_FFFF);
  endtask

  // Window bounds: start inclusive, end exclusive, empty and reversed
  // windows, the extreme neuron and ticks, the most negative current and a
  // rewrite of a slot that is already in use.
  task automatic test_window_edges();
    send_write(6'd0, 10'd5, 32'd10, 32'd20, 32'sh0001_0000);
    send_write(6'd1, 10'd5, 32'd15, 32'd15, 32'sh0100_0000);
    send_write(6'd2, 10'd5, 32'd30, 32'd10, 32'sh0200_0000);
    send_write(6'd3, 10'h3FF, 32'd0, 32'hFFFF_FFFF, 32'sh8000_0000);
    set_window_count(7'd4);
    send_query(10'd5, 32'd10);
    send_query(10'd5, 32'd19);
    send_query(10'd5, 32'd20);
    send_query(10'd5, 32'd15);
    send_query(10'd5, 32'd25);
    send_query(10'h3FF, 32'hFFFF_FFFE);
    send_query(10'h3FF, 32'hFFFF_FFFF);
    send_query(10'd0, 32'd12);
    send_write(6'd0, 10'd5, 32'd10, 32'd20, 32'shFFFF_FFFD);
    send_query(10'd5, 32'd12);
  endtask

  // Writes every slot, so that any active count only ever reaches entries
  // that hold a real window.
  task automatic test_fill_table();
    stim_item_t it;
    new_phase_pool();
    for (int i = 0; i < WINDOWS; i++) begin
      it      = phase_item(100);
      it.func = FUNC_WRITE;
      it.slot = SLOT_W'(i);
      send_item(it);
    end
  endtask

  // Sums beyond the signed 32-bit range clamp at either end; a count above
  // the table size looks at the whole table, and a count of 63 leaves the
  // top slot out.
  task automatic test_saturation();
    set_window_count(7'd127);
    for (int i = 10; i < 13; i++) begin
      send_write(SLOT_W'(i), 10'd777, 32'd100, 32'd200, 32'sh7FFF_FFFF);
    end
    send_write(6'd63, 10'd777, 32'd100, 32'd200, 32'sh0000_0001);
    send_query(10'd777, 32'd150);
    for (int i = 10; i < 13; i++) begin
      send_write(SLOT_W'(i), 10'd777, 32'd100, 32'd200, 32'sh8000_0000);
    end
    send_query(10'd777, 32'd150);
    set_window_count(7'd63);
    send_query(10'd777, 32'd199);
  endtask

  // Phases of random traffic, each under its own active count.
  task automatic test_random_phases();
    logic [CFG_W-1:0] count;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin
          count = 7'd0;
        end
        1: begin
          count = 7'd127;
        end
        2: begin
          count = 7'd64;
        end
        3: begin
          count = 7'd1;
        end
        4: begin
          count = 7'd65;
        end
        default: begin
          count = CFG_W'($urandom_range(127));
        end
      endcase
      new_phase_pool();
      set_window_count(count);
      repeat (150) send_item(phase_item(35));
    end
  endtask

  // A long stretch with neither side idling at all.
  task automatic test_burst_stream();
    new_phase_pool();
    set_window_count(7'd64);
    burst_mode = 1'b1;
    repeat (250) send_item(phase_item(35));
    burst_mode = 1'b0;
  endtask

  // Short groups of items, each followed by a full wait for the results.
  task automatic test_drain_pause();
    new_phase_pool();
    set_window_count(CFG_W'($urandom_range(127)));
    repeat (12) begin
      repeat (10) send_item(phase_item(40));
      drain_results(1'b0);
    end
  endtask

  initial begin
    error_count = 0;
    burst_mode  = 1'b0;
    model_count = '0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_func        <= FUNC_WRITE;
    in_window_slot <= '0;
    in_neuron_id   <= '0;
    in_start_tick  <= '0;
    in_end_tick    <= '0;
    in_amplitude   <= '0;
    in_query_tick  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_window_edges();
    test_fill_table();
    test_saturation();
    test_random_phases();
    test_burst_stream();
    test_drain_pause();

    drain_results(1'b1);
    if (error_count == 0 && expected_currents.size() == 0) begin
      $display("stimulus_window_current_sum_unit verification clean");
    end else begin
      $display("stimulus_window_current_sum_unit verification failed");
    end
    $finish;
  end

endmodule

### stimulus_window_current_sum_unit.f
+incdir+rtl
rtl/swcs_pkg.sv
rtl/swcs_ctrl.sv
rtl/swcs_dpath.sv
rtl/stimulus_window_current_sum_unit.sv
bench/stimulus_window_current_sum_unit_tb.sv
